// ----- rtl/preprocessor_conditional_tracker_macros.svh -----
// assertion macros used by the conditional tracker top level
`ifndef PREPROCESSOR_CONDITIONAL_TRACKER_MACROS_SVH
`define PREPROCESSOR_CONDITIONAL_TRACKER_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define PCT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define PCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pct_pkg.sv -----
// types and constants of the preprocessor conditional tracker
`default_nettype none

package pct_pkg;

    // payload field widths
    localparam int CMD_W = 3;
    localparam int ACT_W = 2;
    localparam int ERR_W = 3;
    localparam int LVL_W = 6;

    // directive kinds, code 7 behaves as other
    typedef enum logic [CMD_W-1:0] {
        CMD_IF     = 3'd0,
        CMD_IFDEF  = 3'd1,
        CMD_IFNDEF = 3'd2,
        CMD_ELIF   = 3'd3,
        CMD_ELSE   = 3'd4,
        CMD_ENDIF  = 3'd5,
        CMD_OTHER  = 3'd6
    } cmd_t;

    // scanner actions
    localparam logic [ACT_W-1:0] ACT_NONE       = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ENTER_SKIP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EXIT_SKIP  = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_STRAY_ELIF   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_STRAY_ELSE   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_STRAY_ENDIF  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_MISSING_IF   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_MISSING_ELIF = 3'd5;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW     = 3'd6;

    // one open conditional; plive is the liveness of the stack below it
    typedef struct packed {
        logic emit;
        logic taken;
        logic plive;
    } stack_entry_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_REPLACE,
        OP_POP
    } stack_kind_t;

    typedef struct packed {
        stack_kind_t  kind;
        stack_entry_t entry;
    } stack_op_t;

    // what the control logic sees of the stack
    typedef struct packed {
        stack_entry_t top;
        stack_entry_t below;
        logic         empty;
        logic         one;
        logic         full;
    } stack_view_t;

endpackage

`default_nettype wire

// ----- rtl/pct_if.sv -----
// directive and result channel interfaces of the conditional tracker
`default_nettype none

interface pct_in_if;
    import pct_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic             condition;
    logic             expression_missing;

    modport source (output valid, command, condition, expression_missing, input ready);
    modport sink (input valid, command, condition, expression_missing, output ready);
endinterface

interface pct_out_if;
    import pct_pkg::*;

    logic             valid;
    logic             ready;
    logic             emitting;
    logic [ACT_W-1:0] action;
    logic [ERR_W-1:0] error_code;
    logic [LVL_W-1:0] nesting_level;

    modport source (output valid, emitting, action, error_code, nesting_level, input ready);
    modport sink (input valid, emitting, action, error_code, nesting_level, output ready);
endinterface

`default_nettype wire

// ----- rtl/pct_stack.sv -----
// conditional stack: memory with cached top entry and prefetched entry below it
`default_nettype none

module pct_stack #(
    parameter int  DEPTH = 32,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pct_pkg::stack_op_t  op,
    output logic [CW-1:0]            count,
    output pct_pkg::stack_view_t     view
);
    import pct_pkg::*;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    stack_entry_t mem [DEPTH];

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] count_dec;
    logic [CW-1:0] rd_count;
    stack_entry_t  top_reg, top_next;
    stack_entry_t  below_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign count_dec = count_reg - 1'b1;

    // next depth, top entry and write port
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        case (op.kind)
            OP_PUSH:
            begin
                count_next = count_reg + 1'b1;
                top_next   = op.entry;
                wr_en      = 1'b1;
                wr_addr    = count_reg[AW-1:0];
            end
            OP_REPLACE:
            begin
                top_next = op.entry;
                wr_en    = 1'b1;
                wr_addr  = count_dec[AW-1:0];
            end
            OP_POP:
            begin
                count_next = count_dec;
                top_next   = below_reg;
            end
            default: ;
        endcase
    end

    // prefetch the entry under the next top; never the entry written this cycle
    assign rd_count = count_next - 2'd2;
    assign rd_addr  = rd_count[AW-1:0];

    // stack storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= op.entry;
        end
        below_reg <= mem[rd_addr];
    end

    // top entry cache
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count       = count_reg;
    assign view.top    = top_reg;
    assign view.below  = below_reg;
    assign view.empty  = (count_reg == '0);
    assign view.one    = (count_reg == CW'(1));
    assign view.full   = (count_reg == DEPTH_C);

endmodule

`default_nettype wire

// ----- rtl/preprocessor_conditional_tracker.sv -----
// top level of the preprocessor conditional tracker
//
// Takes one classified directive per item on the directive channel and returns
// one result item on the result channel: whether following text is live, the
// scanner action (enter or leave skip mode), an error code and the stack depth.
// Both channels use valid/ready; an item moves when both are high.
//
// The result of a directive is registered in the output register when the
// directive is accepted. Throughput: one directive per cycle while results are
// taken. The stack sits in a memory with a registered read; the top entry is
// cached and the entry below it is read ahead every cycle, so pops never stall.
//
// A new directive is accepted while the previous result is taken in the same
// cycle. When the receiver stalls, the result holds and directive ready drops
// until it is taken.
//
// Reset empties the stack and leaves skip mode at once; the stack memory is
// not cleared, since only entries written by pushes or replaces are ever used.
`default_nettype none
`include "preprocessor_conditional_tracker_macros.svh"

module preprocessor_conditional_tracker #(
    parameter int STACK_DEPTH      = 32,
    parameter int MAX_DEAD_NESTING = 255
) (
    input wire logic  clk,
    input wire logic  rst_n,
    pct_in_if.sink    directive,
    pct_out_if.source result
);
    import pct_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = $clog2(MAX_DEAD_NESTING + 1);
    localparam logic [DW-1:0] DEAD_MAX = DW'(MAX_DEAD_NESTING);

    logic          accept;
    logic [CW-1:0] count;
    stack_view_t   view;
    stack_op_t     op;
    stack_op_t     apply_op;
    stack_op_t     mode_op;
    cmd_t          cmd;

    logic             live;
    logic             had;
    logic             lpar;
    logic             cond_val;
    logic             evaluate;
    logic             is_open;
    logic             is_close;
    logic             apply_live;
    logic [ERR_W-1:0] apply_err;

    logic             skip_reg, skip_next;
    logic [DW-1:0]    dead_reg, dead_next;
    logic             live_after;
    logic [ACT_W-1:0] act;
    logic [ERR_W-1:0] err;
    logic [CW-1:0]    level;

    logic             out_valid_reg;
    logic             emitting_reg;
    logic [ACT_W-1:0] action_reg;
    logic [ERR_W-1:0] error_reg;
    logic [LVL_W-1:0] level_reg;

    assign cmd    = cmd_t'(directive.command);
    assign accept = directive.valid && directive.ready;

    // one directive applied to the stack
    always_comb
    begin
        live       = view.empty || view.top.emit;
        had        = view.top.taken;
        lpar       = view.top.plive;
        evaluate   = 1'b0;
        cond_val   = 1'b0;
        apply_op   = '{kind: OP_NONE, entry: '0};
        apply_err  = ERR_NONE;
        apply_live = live;
        case (cmd)
            CMD_IF, CMD_IFDEF, CMD_IFNDEF:
            begin
                if (cmd == CMD_IF)
                begin
                    cond_val = live && !directive.expression_missing && directive.condition;
                    if (live && directive.expression_missing)
                    begin
                        apply_err = ERR_MISSING_IF;
                    end
                end
                else if (cmd == CMD_IFDEF)
                begin
                    cond_val = live && directive.condition;
                end
                else
                begin
                    cond_val = live && !directive.condition;
                end
                if (view.full)
                begin
                    apply_err = ERR_OVERFLOW;
                end
                else
                begin
                    apply_op   = '{kind: OP_PUSH,
                                   entry: '{emit: cond_val, taken: cond_val, plive: live}};
                    apply_live = cond_val;
                end
            end
            CMD_ELIF:
            begin
                if (view.empty)
                begin
                    apply_err = ERR_STRAY_ELIF;
                end
                else
                begin
                    evaluate = lpar && !had;
                    cond_val = evaluate && !directive.expression_missing
                               && directive.condition;
                    if (evaluate && directive.expression_missing)
                    begin
                        apply_err = ERR_MISSING_ELIF;
                    end
                    apply_op   = '{kind: OP_REPLACE,
                                   entry: '{emit: cond_val, taken: had || cond_val,
                                            plive: lpar}};
                    apply_live = cond_val;
                end
            end
            CMD_ELSE:
            begin
                if (view.empty)
                begin
                    apply_err = ERR_STRAY_ELSE;
                end
                else
                begin
                    apply_op   = '{kind: OP_REPLACE,
                                   entry: '{emit: lpar && !had, taken: 1'b1, plive: lpar}};
                    apply_live = lpar && !had;
                end
            end
            CMD_ENDIF:
            begin
                if (view.empty)
                begin
                    apply_err = ERR_STRAY_ENDIF;
                end
                else
                begin
                    apply_op   = '{kind: OP_POP, entry: '0};
                    apply_live = view.one || view.below.emit;
                end
            end
            default: ;
        endcase
    end

    assign is_open  = (cmd == CMD_IF) || (cmd == CMD_IFDEF) || (cmd == CMD_IFNDEF);
    assign is_close = (cmd == CMD_ELIF) || (cmd == CMD_ELSE) || (cmd == CMD_ENDIF);

    // live and skip mode handling
    always_comb
    begin
        mode_op    = '{kind: OP_NONE, entry: '0};
        skip_next  = skip_reg;
        dead_next  = dead_reg;
        act        = ACT_NONE;
        err        = ERR_NONE;
        live_after = live;
        if (!skip_reg)
        begin
            mode_op    = apply_op;
            err        = apply_err;
            live_after = apply_live;
            if (!apply_live)
            begin
                dead_next = '0;
                skip_next = 1'b1;
                act       = ACT_ENTER_SKIP;
            end
        end
        else if (is_open)
        begin
            if (dead_reg != DEAD_MAX)
            begin
                dead_next = dead_reg + 1'b1;
            end
        end
        else if (dead_reg != '0)
        begin
            if (cmd == CMD_ENDIF)
            begin
                dead_next = dead_reg - 1'b1;
            end
        end
        else if (is_close)
        begin
            mode_op    = apply_op;
            err        = apply_err;
            live_after = apply_live;
            if (apply_live)
            begin
                skip_next = 1'b0;
                act       = ACT_EXIT_SKIP;
            end
        end
    end

    // stack changes only for an accepted item
    assign op = accept ? mode_op : stack_op_t'{kind: OP_NONE, entry: '0};

    // depth after the directive
    always_comb
    begin
        level = count;
        case (mode_op.kind)
            OP_PUSH: level = count + 1'b1;
            OP_POP:  level = count - 1'b1;
            default: ;
        endcase
    end

    pct_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .count (count),
        .view  (view)
    );

    // mode state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg      <= 1'b0;
            dead_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                skip_reg      <= skip_next;
                dead_reg      <= dead_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            emitting_reg <= live_after;
            action_reg   <= act;
            error_reg    <= err;
            level_reg    <= LVL_W'(level);
        end
    end

    assign directive.ready      = !out_valid_reg || result.ready;
    assign result.valid         = out_valid_reg;
    assign result.emitting      = emitting_reg;
    assign result.action        = action_reg;
    assign result.error_code    = error_reg;
    assign result.nesting_level = level_reg;

    // skip mode always mirrors a dead top entry
    `PCT_ASSERT_ALWAYS(a_skip_tracks_top, skip_reg == (!view.empty && !view.top.emit), "skip mode out of step with stack top")
    // dead nesting only counts inside skip mode
    `PCT_ASSERT_ALWAYS(a_dead_only_skip, (dead_reg == '0) || skip_reg, "dead nesting nonzero while live")
    // an accepted push grows the stack by one
    `PCT_ASSERT_NEXT(a_push_grows, accept && (mode_op.kind == OP_PUSH), count == $past(count) + 1'b1, "push did not grow stack")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the preprocessor conditional tracker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pct_pkg::*;

    localparam int STACK_DEPTH      = 32;
    localparam int MAX_DEAD_NESTING = 255;
    localparam int SAW              = $clog2(STACK_DEPTH);
    localparam int CYCLE_LIMIT      = 400000;
    localparam int HOLD_LEN         = 120;
    localparam int SETTLE_CYCLES    = 10;

    // command code 7 has no name in the package and behaves as other
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             condition;
        logic             expression_missing;
    } directive_t;

    typedef struct packed {
        logic             emitting;
        logic [ACT_W-1:0] action;
        logic [ERR_W-1:0] error_code;
        logic [LVL_W-1:0] nesting_level;
    } outcome_t;

    logic clk;
    logic rst_n;

    pct_in_if  dir_if ();
    pct_out_if res_if ();

    preprocessor_conditional_tracker #(
        .STACK_DEPTH      (STACK_DEPTH),
        .MAX_DEAD_NESTING (MAX_DEAD_NESTING)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .directive (dir_if),
        .result    (res_if)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    directive_t  pending_dirs[$];
    outcome_t    awaited_results[$];
    int unsigned error_count;
    int unsigned result_count;
    int unsigned random_items;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          dir_accepted;
    bit          hold_req;
    int unsigned hold_cycles;
    logic        hold_active;

    // shadow of the conditional stack and skip state
    bit          emit_bits[STACK_DEPTH];
    bit          taken_bits[STACK_DEPTH];
    int unsigned stack_fill;
    bit          skipping;
    int unsigned dead_depth;

    function automatic bit top_live();
        if (stack_fill == 0)
            return 1'b1;
        return emit_bits[SAW'(stack_fill - 1)];
    endfunction

    function automatic logic [ERR_W-1:0] stack_push(bit e, bit t);
        if (stack_fill >= STACK_DEPTH)
            return ERR_OVERFLOW;
        emit_bits[SAW'(stack_fill)]  = e;
        taken_bits[SAW'(stack_fill)] = t;
        stack_fill++;
        return ERR_NONE;
    endfunction

    // one directive against the stack, returns the error it raises
    function automatic logic [ERR_W-1:0] apply_directive(directive_t d);
        bit               live;
        bit               had;
        bit               c;
        bit               now;
        logic [ERR_W-1:0] err;
        logic [ERR_W-1:0] push_err;
        live = top_live();
        err  = ERR_NONE;
        case (d.command)
            CMD_IF:
            begin
                c = 1'b0;
                if (live)
                begin
                    if (d.expression_missing)
                        err = ERR_MISSING_IF;
                    else
                        c = d.condition;
                end
                push_err = stack_push(c, c);
                if (push_err != ERR_NONE)
                    err = push_err;
            end
            CMD_IFDEF:
            begin
                c   = live & d.condition;
                err = stack_push(c, c);
            end
            CMD_IFNDEF:
            begin
                c   = live & ~d.condition;
                err = stack_push(c, c);
            end
            CMD_ELIF:
            begin
                if (stack_fill == 0)
                    err = ERR_STRAY_ELIF;
                else
                begin
                    had = taken_bits[SAW'(stack_fill - 1)];
                    stack_fill--;
                    live = top_live();
                    c = 1'b0;
                    if (live && !had)
                    begin
                        if (d.expression_missing)
                            err = ERR_MISSING_ELIF;
                        else
                            c = d.condition;
                    end
                    now = live & ~had & c;
                    void'(stack_push(now, had | now));
                end
            end
            CMD_ELSE:
            begin
                if (stack_fill == 0)
                    err = ERR_STRAY_ELSE;
                else
                begin
                    had = taken_bits[SAW'(stack_fill - 1)];
                    stack_fill--;
                    now = top_live() & ~had;
                    void'(stack_push(now, 1'b1));
                end
            end
            CMD_ENDIF:
            begin
                if (stack_fill == 0)
                    err = ERR_STRAY_ENDIF;
                else
                    stack_fill--;
            end
            default:
                err = ERR_NONE;
        endcase
        return err;
    endfunction

    // expected outcome of one accepted directive
    function automatic outcome_t track_directive(directive_t d);
        outcome_t r;
        r.action     = ACT_NONE;
        r.error_code = ERR_NONE;
        if (!skipping)
        begin
            r.error_code = apply_directive(d);
            if (!top_live())
            begin
                dead_depth = 0;
                skipping   = 1'b1;
                r.action   = ACT_ENTER_SKIP;
            end
        end
        else if (d.command inside {CMD_IF, CMD_IFDEF, CMD_IFNDEF})
        begin
            if (dead_depth < MAX_DEAD_NESTING)
                dead_depth++;
        end
        else if (dead_depth > 0)
        begin
            if (d.command == CMD_ENDIF)
                dead_depth--;
        end
        else if (d.command inside {CMD_ELIF, CMD_ELSE, CMD_ENDIF})
        begin
            r.error_code = apply_directive(d);
            if (top_live())
            begin
                skipping = 1'b0;
                r.action = ACT_EXIT_SKIP;
            end
        end
        r.emitting      = top_live();
        r.nesting_level = stack_fill[LVL_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    // stimulus helpers
    function automatic bit coin();
        return 1'($urandom_range(1));
    endfunction

    task automatic add_dir(logic [CMD_W-1:0] cmd, bit cond, bit miss);
        directive_t d;
        d.command            = cmd;
        d.condition          = cond;
        d.expression_missing = miss;
        pending_dirs = {pending_dirs, d};
        random_items++;
    endtask

    function automatic logic [CMD_W-1:0] open_kind();
        case ($urandom_range(2))
            0:       return CMD_IF;
            1:       return CMD_IFDEF;
            default: return CMD_IFNDEF;
        endcase
    endfunction

    function automatic bit rare_missing();
        return $urandom_range(99) < 8;
    endfunction

    // well-formed conditional with random arms and nested content
    task automatic gen_body(int unsigned lvl);
        int unsigned n;
        n = $urandom_range(2);
        repeat (n)
        begin
            if (lvl < 12 && $urandom_range(99) < 30)
                gen_cond(lvl + 1);
            else
                add_dir(CMD_OTHER, coin(), coin());
        end
    endtask

    task automatic gen_cond(int unsigned lvl);
        int unsigned arms;
        add_dir(open_kind(), coin(), rare_missing());
        gen_body(lvl);
        arms = $urandom_range(2);
        repeat (arms)
        begin
            add_dir(CMD_ELIF, coin(), rare_missing());
            gen_body(lvl);
        end
        if ($urandom_range(1))
        begin
            add_dir(CMD_ELSE, coin(), coin());
            gen_body(lvl);
        end
        add_dir(CMD_ENDIF, coin(), coin());
    endtask

    // mostly well-formed blocks, some raw noise, truncated and stray sequences
    task automatic fill_random(int unsigned target);
        int unsigned r;
        int unsigned n;
        while (random_items < target)
        begin
            r = $urandom_range(99);
            if (r < 80)
                gen_cond(0);
            else if (r < 88)
                add_dir(CMD_W'($urandom_range(7)), coin(), coin());
            else if (r < 94)
            begin
                add_dir(open_kind(), coin(), rare_missing());
                gen_body(1);
            end
            else
            begin
                n = $urandom_range(3, 1);
                repeat (n)
                begin
                    case ($urandom_range(3))
                        0:       add_dir(CMD_ELIF, coin(), coin());
                        1:       add_dir(CMD_ELSE, coin(), coin());
                        default: add_dir(CMD_ENDIF, coin(), coin());
                    endcase
                end
            end
        end
    endtask

    task automatic wait_sent();
        while (pending_dirs.size() != 0 || dir_if.valid)
            @(posedge clk);
    endtask

    // directive driver
    always @(negedge clk)
    begin : drive_directive
        directive_t nxt;
        logic       v;
        if (rst_n)
        begin
            v = dir_if.valid;
            if (!dir_if.valid || dir_accepted)
            begin
                v = 1'b0;
                if (pending_dirs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_dirs.pop_front();
                    v   = 1'b1;
                    dir_if.command            <= nxt.command;
                    dir_if.condition          <= nxt.condition;
                    dir_if.expression_missing <= nxt.expression_missing;
                end
            end
            dir_if.valid <= v;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_req && hold_cycles < HOLD_LEN)
            hold_cycles <= hold_cycles + 1;
    end

    assign hold_active = hold_req && (hold_cycles < HOLD_LEN);

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
            res_if.ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on directive acceptance, check on result acceptance
    always @(posedge clk)
    begin : watch
        directive_t d;
        outcome_t   got;
        outcome_t   want;
        dir_accepted = rst_n && dir_if.valid && dir_if.ready;
        if (dir_accepted)
        begin
            d = '{dir_if.command, dir_if.condition, dir_if.expression_missing};
            awaited_results = {awaited_results, track_directive(d)};
        end
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = '{res_if.emitting, res_if.action, res_if.error_code, res_if.nesting_level};
            if (awaited_results.size() == 0)
                report_mismatch("result item with no directive outstanding");
            else
            begin
                want = awaited_results.pop_front();
                if (got.emitting !== want.emitting)
                    report_mismatch($sformatf("item %0d emitting: got %0b, expected %0b",
                        result_count, got.emitting, want.emitting));
                if (got.action !== want.action)
                    report_mismatch($sformatf("item %0d action: got %0d, expected %0d",
                        result_count, got.action, want.action));
                if (got.error_code !== want.error_code)
                    report_mismatch($sformatf("item %0d error_code: got %0d, expected %0d",
                        result_count, got.error_code, want.error_code));
                if (got.nesting_level !== want.nesting_level)
                    report_mismatch($sformatf("item %0d nesting_level: got %0d, expected %0d",
                        result_count, got.nesting_level, want.nesting_level));
            end
            result_count++;
        end
    end

    // run limit
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : stimulus
        dir_if.valid              = 1'b0;
        dir_if.command            = CMD_OTHER;
        dir_if.condition          = 1'b0;
        dir_if.expression_missing = 1'b0;
        res_if.ready              = 1'b0;
        rst_n         = 1'b0;
        hold_req      = 1'b0;
        hold_cycles   = 0;
        dir_accepted  = 1'b0;
        error_count   = 0;
        result_count  = 0;
        random_items  = 0;
        stack_fill    = 0;
        skipping      = 1'b0;
        dead_depth    = 0;
        send_idle_pct = 33;
        recv_idle_pct = 82;

        // stray closers on an empty stack
        add_dir(CMD_ELIF, 1'b1, 1'b1);
        add_dir(CMD_ELSE, 1'b0, 1'b0);
        add_dir(CMD_ENDIF, 1'b1, 1'b1);
        // missing expressions on if and elif, then an elif that goes live and a dead else
        add_dir(CMD_IF, 1'b1, 1'b1);
        add_dir(CMD_ELIF, 1'b1, 1'b1);
        add_dir(CMD_ELIF, 1'b1, 1'b0);
        add_dir(CMD_ELSE, 1'b1, 1'b0);
        add_dir(CMD_ENDIF, 1'b0, 1'b0);
        // dead branch with nested conditionals and ignored directives
        add_dir(CMD_IFDEF, 1'b1, 1'b0);
        add_dir(CMD_IFNDEF, 1'b1, 1'b0);
        add_dir(CMD_IF, 1'b1, 1'b0);
        add_dir(CMD_IFDEF, 1'b0, 1'b1);
        add_dir(CMD_ELSE, 1'b1, 1'b1);
        add_dir(CMD_ENDIF, 1'b0, 1'b0);
        add_dir(CMD_OTHER, 1'b1, 1'b1);
        add_dir(CMD_ELIF, 1'b1, 1'b0);
        add_dir(CMD_ENDIF, 1'b1, 1'b0);
        add_dir(CMD_UNUSED, 1'b1, 1'b1);
        add_dir(CMD_ELSE, 1'b0, 1'b1);
        add_dir(CMD_UNUSED, 1'b0, 1'b0);
        add_dir(CMD_ENDIF, 1'b0, 1'b1);
        // elif after a taken branch
        add_dir(CMD_IFNDEF, 1'b0, 1'b1);
        add_dir(CMD_ELIF, 1'b1, 1'b0);
        add_dir(CMD_ENDIF, 1'b1, 1'b1);
        add_dir(CMD_ENDIF, 1'b0, 1'b0);
        fill_random(200);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_sent();

        // sender slow, receiver mostly ready
        send_idle_pct = 82;
        recv_idle_pct = 33;
        fill_random(330);
        wait_sent();

        // full rate, opening with a long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        // close whatever the noise left open
        repeat (70) add_dir(CMD_ENDIF, coin(), coin());
        // fill the stack, then push onto a full stack
        repeat (STACK_DEPTH) add_dir(CMD_IF, 1'b1, 1'b0);
        add_dir(CMD_IF, 1'b1, 1'b1);
        add_dir(CMD_IFDEF, 1'b1, 1'b0);
        repeat (STACK_DEPTH + 2) add_dir(CMD_ENDIF, coin(), coin());
        // dead nesting counter driven past its limit and back
        add_dir(CMD_IF, 1'b0, 1'b0);
        repeat (MAX_DEAD_NESTING + 5) add_dir(open_kind(), coin(), coin());
        repeat (MAX_DEAD_NESTING) add_dir(CMD_ENDIF, coin(), coin());
        add_dir(CMD_ELSE, 1'b0, 1'b0);
        add_dir(CMD_ENDIF, 1'b0, 1'b0);
        fill_random(1000);
        wait_sent();

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
